// ===== design/msfl_pkg.sv =====
// ----------------------------------------------------------------------------
// msfl_pkg
// Shared types, constants and codes for the motion sensor and fault latch.
// ----------------------------------------------------------------------------
package msfl_pkg;

   // fraction bits of the position inputs
   localparam int FRAC_BITS = 8;
   localparam int POS_W     = 32;
   localparam int CUR_W     = 16;
   localparam int CNT_W     = 24;
   localparam int SCALE_Q   = 16;
   localparam int CSR_W     = 32;
   localparam int FLAGS_W   = 13;
   localparam int HALF_W    = 31;
   localparam int CLIM_W    = 15;

   localparam longint CNT_MAX = (longint'(1) <<< (CNT_W - 1)) - 1;
   localparam longint CNT_MIN = -(longint'(1) <<< (CNT_W - 1));

   // sensor_flags bit positions
   localparam int FLAG_POS_EN     = 0;
   localparam int FLAG_NEG_EN     = 1;
   localparam int FLAG_HOME_EN    = 2;
   localparam int FLAG_INDEX_EN   = 3;
   localparam int FLAG_POS_NC     = 4;
   localparam int FLAG_NEG_NC     = 5;
   localparam int FLAG_HOME_NC    = 6;
   localparam int FLAG_INJECT     = 7;
   localparam int FLAG_POS_DISC   = 8;
   localparam int FLAG_NEG_DISC   = 9;
   localparam int FLAG_HOME_DISC  = 10;
   localparam int FLAG_INDEX_DISC = 11;
   localparam int FLAG_ENC_FAULT  = 12;

   typedef enum logic [2:0] {
      CSR_SENSOR_FLAGS,
      CSR_POS_LIMIT,
      CSR_NEG_LIMIT,
      CSR_HOME_POSITION,
      CSR_HOME_HALF_WIDTH,
      CSR_INDEX_POSITION,
      CSR_OUTPUT_SCALE,
      CSR_CURRENT_LIMIT
   } csr_index_type;

   typedef enum logic [2:0] {
      FAULT_NONE,
      FAULT_OVERCURRENT,
      FAULT_WINDING_HOT,
      FAULT_GEARBOX_HOT,
      FAULT_ENCODER
   } fault_code_type;

   typedef struct packed {
      logic [FLAGS_W-1:0]      sensor_flags;
      logic signed [POS_W-1:0] pos_limit_position;
      logic signed [POS_W-1:0] neg_limit_position;
      logic signed [POS_W-1:0] home_position;
      logic [HALF_W-1:0]       home_half_width;
      logic signed [POS_W-1:0] index_position;
      logic [POS_W-1:0]        output_scale;
      logic [CLIM_W-1:0]       current_limit;
   } cfg_type;

   typedef struct packed {
      logic signed [POS_W-1:0] motor_position;
      logic signed [POS_W-1:0] load_position;
      logic signed [CUR_W-1:0] motor_current;
      logic                    winding_hot;
      logic                    gearbox_hot;
   } item_type;

   typedef struct packed {
      logic                    pos_limit;
      logic                    neg_limit;
      logic                    home;
      logic signed [POS_W-1:0] prev_motor;
      logic                    fault_latched;
      fault_code_type          latched_code;
   } state_type;

   typedef struct packed {
      logic                    pos_limit_active;
      logic                    neg_limit_active;
      logic                    home_active;
      logic                    index_pulse;
      logic                    limit_changed;
      logic                    home_changed;
      logic signed [CNT_W-1:0] encoder_count;
      logic signed [CNT_W-1:0] output_count;
      logic                    fault_active;
      fault_code_type          fault_code;
      logic                    fault_new;
   } result_type;

endpackage

// ===== design/motion_sensor_and_fault_latch.sv =====
// ----------------------------------------------------------------------------
// motion_sensor_and_fault_latch
// rsp_valid rises once an accepted req has passed the input register and eval
// into the result queue. Throughput: one word per cycle while it is not full;
// the single eval pass and the two-word result queue set that rate, and the
// queue lets a word in while one waits on rsp.
// Reset (synchronous, active high): CSRs to defaults, switch state, previous
// motor position and fault latch cleared, pipeline and queue emptied.
// ----------------------------------------------------------------------------
module motion_sensor_and_fault_latch (
   input  logic                                   clock,
   input  logic                                   reset,
   // tick input
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic signed [msfl_pkg::POS_W-1:0]      req_motor_position,
   input  logic signed [msfl_pkg::POS_W-1:0]      req_load_position,
   input  logic signed [msfl_pkg::CUR_W-1:0]      req_motor_current,
   input  logic                                   req_winding_hot,
   input  logic                                   req_gearbox_hot,
   // result output
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic                                   rsp_pos_limit_active,
   output logic                                   rsp_neg_limit_active,
   output logic                                   rsp_home_active,
   output logic                                   rsp_index_pulse,
   output logic                                   rsp_limit_changed,
   output logic                                   rsp_home_changed,
   output logic signed [msfl_pkg::CNT_W-1:0]      rsp_encoder_count,
   output logic signed [msfl_pkg::CNT_W-1:0]      rsp_output_count,
   output logic                                   rsp_fault_active,
   output logic [2:0]                             rsp_fault_code,
   output logic                                   rsp_fault_new,
   // register write port
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [2:0]                             csr_index,
   input  logic [msfl_pkg::CSR_W-1:0]             csr_wdata
);
   import msfl_pkg::*;

   // CSR bank
   cfg_type     cfg_ff;
   // input register
   item_type    item_ff;
   logic        item_valid_ff;
   // tick-to-tick state
   state_type   state_ff;

   state_type   state_nx;
   result_type  eval_word, out_word;
   logic        q_full;
   logic        fire;
   logic        req_fire;
   logic        item_valid_in;

   // Eval fires when a word is staged and the queue has room; the input
   // register refills in the same cycle, so ticks flow back to back.
   assign fire      = item_valid_ff && !q_full;
   assign req_ready = !item_valid_ff || fire;
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   always_comb begin
      item_valid_in = item_valid_ff;
      if (fire)     item_valid_in = 1'b0;
      if (req_fire) item_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      if (req_fire) begin
         item_ff.motor_position <= req_motor_position;
         item_ff.load_position  <= req_load_position;
         item_ff.motor_current  <= req_motor_current;
         item_ff.winding_hot    <= req_winding_hot;
         item_ff.gearbox_hot    <= req_gearbox_hot;
      end
   end

   // CSR writes; each register keeps only its own width
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sensor_flags       <= '0;
         cfg_ff.pos_limit_position <= POS_W'(32'h7FFF_FFFF);
         cfg_ff.neg_limit_position <= POS_W'(32'h8000_0000);
         cfg_ff.home_position      <= '0;
         cfg_ff.home_half_width    <= '0;
         cfg_ff.index_position     <= '0;
         cfg_ff.output_scale       <= POS_W'(32'h0001_0000);
         cfg_ff.current_limit      <= '1;
      end else if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_SENSOR_FLAGS:    cfg_ff.sensor_flags       <= csr_wdata[FLAGS_W-1:0];
            CSR_POS_LIMIT:       cfg_ff.pos_limit_position <= csr_wdata[POS_W-1:0];
            CSR_NEG_LIMIT:       cfg_ff.neg_limit_position <= csr_wdata[POS_W-1:0];
            CSR_HOME_POSITION:   cfg_ff.home_position      <= csr_wdata[POS_W-1:0];
            CSR_HOME_HALF_WIDTH: cfg_ff.home_half_width    <= csr_wdata[HALF_W-1:0];
            CSR_INDEX_POSITION:  cfg_ff.index_position     <= csr_wdata[POS_W-1:0];
            CSR_OUTPUT_SCALE:    cfg_ff.output_scale       <= csr_wdata[POS_W-1:0];
            CSR_CURRENT_LIMIT:   cfg_ff.current_limit      <= csr_wdata[CLIM_W-1:0];
            default:             cfg_ff <= cfg_ff;
         endcase
      end
   end

   msfl_eval u_eval (
      .item       (item_ff),
      .cfg        (cfg_ff),
      .state      (state_ff),
      .result     (eval_word),
      .state_next (state_nx)
   );

   // switch regs, previous position and fault latch advance once per tick
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (fire) begin
         state_ff <= state_nx;
      end
   end

   msfl_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (fire),
      .push_word (eval_word),
      .full      (q_full),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_word  (out_word)
   );

   assign rsp_pos_limit_active = out_word.pos_limit_active;
   assign rsp_neg_limit_active = out_word.neg_limit_active;
   assign rsp_home_active      = out_word.home_active;
   assign rsp_index_pulse      = out_word.index_pulse;
   assign rsp_limit_changed    = out_word.limit_changed;
   assign rsp_home_changed     = out_word.home_changed;
   assign rsp_encoder_count    = out_word.encoder_count;
   assign rsp_output_count     = out_word.output_count;
   assign rsp_fault_active     = out_word.fault_active;
   assign rsp_fault_code       = out_word.fault_code;
   assign rsp_fault_new        = out_word.fault_new;

endmodule

// ===== design/msfl_eval.sv =====
// ----------------------------------------------------------------------------
// msfl_eval
// Per-tick evaluation: switches, index, counts and fault selection.
// ----------------------------------------------------------------------------
module msfl_eval (
   input  msfl_pkg::item_type   item,
   input  msfl_pkg::cfg_type    cfg,
   input  msfl_pkg::state_type  state,
   output msfl_pkg::result_type result,
   output msfl_pkg::state_type  state_next
);
   import msfl_pkg::*;

   localparam int OUT_SHIFT = SCALE_Q + FRAC_BITS;
   localparam int EW = POS_W + 1;
   localparam int PW = 2 * EW;
   localparam logic signed [EW-1:0] ENC_BIAS = EW'((longint'(1) <<< FRAC_BITS) - 1);
   localparam logic signed [PW-1:0] OUT_BIAS = PW'((longint'(1) <<< OUT_SHIFT) - 1);
   localparam logic signed [EW-1:0] ENC_HI = EW'(CNT_MAX);
   localparam logic signed [EW-1:0] ENC_LO = EW'(CNT_MIN);
   localparam logic signed [PW-1:0] OUT_HI = PW'(CNT_MAX);
   localparam logic signed [PW-1:0] OUT_LO = PW'(CNT_MIN);

   logic [FLAGS_W-1:0]   f;
   logic                 inj, enc_fault;
   logic                 pos_t, neg_t, home_t;
   logic signed [EW-1:0] load_x, motor_x, home_x, home_diff;
   logic [EW-1:0]        home_mag;
   logic signed [EW-1:0] enc_sum, enc_q;
   logic signed [PW-1:0] out_prod, out_sum, out_q;
   logic signed [CUR_W:0] cur_x;
   logic [CUR_W:0]       cur_mag;
   logic                 over_cur;
   fault_code_type       code;

   always_comb begin
      f         = cfg.sensor_flags;
      inj       = f[FLAG_INJECT];
      enc_fault = inj && f[FLAG_ENC_FAULT];
      load_x    = {item.load_position[POS_W-1], item.load_position};
      motor_x   = {item.motor_position[POS_W-1], item.motor_position};
      home_x    = {cfg.home_position[POS_W-1], cfg.home_position};

      state_next = state;

      // limit and home switches, raw trigger then polarity
      pos_t = item.load_position >= cfg.pos_limit_position;
      if (inj && f[FLAG_POS_DISC]) pos_t = f[FLAG_POS_NC];
      neg_t = item.load_position <= cfg.neg_limit_position;
      if (inj && f[FLAG_NEG_DISC]) neg_t = f[FLAG_NEG_NC];

      home_diff = load_x - home_x;
      home_mag  = (home_diff < 0) ? EW'(-home_diff) : EW'(home_diff);
      home_t    = home_mag < {2'b00, cfg.home_half_width};
      if (inj && f[FLAG_HOME_DISC]) home_t = f[FLAG_HOME_NC];

      if (f[FLAG_POS_EN])  state_next.pos_limit = pos_t ^ f[FLAG_POS_NC];
      if (f[FLAG_NEG_EN])  state_next.neg_limit = neg_t ^ f[FLAG_NEG_NC];
      if (f[FLAG_HOME_EN]) state_next.home      = home_t ^ f[FLAG_HOME_NC];

      result.index_pulse = 1'b0;
      if (f[FLAG_INDEX_EN] && !f[FLAG_INDEX_DISC]) begin
         result.index_pulse =
            (state.prev_motor < cfg.index_position &&
             item.motor_position >= cfg.index_position) ||
            (state.prev_motor > cfg.index_position &&
             item.motor_position <= cfg.index_position);
      end
      state_next.prev_motor = item.motor_position;

      // encoder count: truncate toward zero, saturate; zero on injected encoder fault
      enc_sum = motor_x + ((motor_x < 0) ? ENC_BIAS : '0);
      enc_q   = enc_sum >>> FRAC_BITS;
      if (enc_fault)            result.encoder_count = '0;
      else if (enc_q > ENC_HI)  result.encoder_count = CNT_W'(CNT_MAX);
      else if (enc_q < ENC_LO)  result.encoder_count = CNT_W'(CNT_MIN);
      else                      result.encoder_count = enc_q[CNT_W-1:0];

      // output count: load times Q16.16 scale
      out_prod = load_x * $signed({1'b0, cfg.output_scale});
      out_sum  = out_prod + ((out_prod < 0) ? OUT_BIAS : '0);
      out_q    = out_sum >>> OUT_SHIFT;
      if (out_q > OUT_HI)       result.output_count = CNT_W'(CNT_MAX);
      else if (out_q < OUT_LO)  result.output_count = CNT_W'(CNT_MIN);
      else                      result.output_count = out_q[CNT_W-1:0];

      // faults, lowest code wins, first one sticks
      cur_x    = {item.motor_current[CUR_W-1], item.motor_current};
      cur_mag  = (cur_x < 0) ? (CUR_W+1)'(-cur_x) : (CUR_W+1)'(cur_x);
      over_cur = cur_mag > {2'b00, cfg.current_limit};
      priority if (over_cur)     code = FAULT_OVERCURRENT;
      else if (item.winding_hot) code = FAULT_WINDING_HOT;
      else if (item.gearbox_hot) code = FAULT_GEARBOX_HOT;
      else if (enc_fault)        code = FAULT_ENCODER;
      else                       code = FAULT_NONE;

      result.fault_new = (code != FAULT_NONE) && !state.fault_latched;
      if (result.fault_new) begin
         state_next.fault_latched = 1'b1;
         state_next.latched_code  = code;
      end

      result.pos_limit_active = state_next.pos_limit;
      result.neg_limit_active = state_next.neg_limit;
      result.home_active      = state_next.home;
      result.limit_changed    = (state_next.pos_limit != state.pos_limit) ||
                                (state_next.neg_limit != state.neg_limit);
      result.home_changed     = state_next.home != state.home;
      result.fault_active     = state_next.fault_latched;
      result.fault_code       = state_next.latched_code;
   end

endmodule

// ===== design/msfl_rsp_queue.sv =====
// ----------------------------------------------------------------------------
// msfl_rsp_queue
// Two-word result queue; full is registered so ready does not see rsp_ready.
// ----------------------------------------------------------------------------
module msfl_rsp_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  msfl_pkg::result_type push_word,
   output logic                 full,
   output logic                 out_valid,
   input  logic                 out_ready,
   output msfl_pkg::result_type out_word
);
   import msfl_pkg::*;

   result_type  slot_ff [2];
   logic        wr_ptr_ff, rd_ptr_ff;
   logic        wr_ptr_in, rd_ptr_in;
   logic [1:0]  count_ff, count_in;
   logic        pop;

   assign pop       = out_ready && (count_ff != 2'd0);
   assign full      = count_ff == 2'd2;
   assign out_valid = count_ff != 2'd0;
   assign out_word  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_word;
      end
   end

endmodule
